/* rtl/x86_alu_with_flags_assert.svh */
// Assertion macros for the x86 ALU checker.
`ifndef X86_ALU_WITH_FLAGS_ASSERT_SVH
`define X86_ALU_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define XALU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("x86 alu check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define XALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("x86 alu check failed");

`endif

/* rtl/xalu_pkg.sv */
// Types and constants shared by the x86 ALU files.
`default_nettype none
package xalu_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned BYTE_TOP  = 7;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WORD_TOP  = 31;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MOV = 3'd2,
    OP_XOR = 3'd3,
    OP_CMP = 3'd4,
    OP_AND = 3'd5,
    OP_OR  = 3'd6
  } opcode_t;

  typedef struct packed {
    logic of;
    logic cf;
    logic sf;
    logic zf;
  } flags_t;

  typedef struct packed {
    opcode_t     opcode;
    logic        byte_size;
    logic [31:0] dst_value;
    logic [31:0] src_value;
  } alu_word_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        write_dest;
    flags_t      flags;
  } alu_res_t;

endpackage
`default_nettype wire

/* rtl/x86_alu_with_flags.sv */
// Top level of the x86 ALU with ZF, SF, CF and OF flags.
// One word per cycle: each word is captured in an input register, passes the
// adder and flag logic, and moves into the result register when the output
// side advances, so throughput is one word per cycle while out_stall is low.
// The flag register is updated in word order as each word moves into the
// result register; mov and the unused opcode report the flags left by the
// last flag-setting word. A stall on the result side holds the result
// register and, while the input register holds a word, holds it as well and
// raises in_stall in the same cycle.
`default_nettype none
module x86_alu_with_flags
  import xalu_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic        in_byte_size,
  input  wire logic [31:0] in_dst_value,
  input  wire logic [31:0] in_src_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_result_value,
  output logic             out_write_dest,
  output logic             out_zero_flag,
  output logic             out_sign_flag,
  output logic             out_carry_flag,
  output logic             out_overflow_flag
);

  logic      in_vld_r;
  logic      in_vld_nxt;
  alu_word_t in_word_r;
  logic      out_vld_r;
  logic      out_vld_nxt;
  alu_res_t  out_res_r;
  flags_t    flags_r;
  alu_res_t  alu_res;
  logic      adv_out;
  logic      adv_in;

  assign adv_out  = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv_out;
  assign adv_in   = in_valid && !in_stall;

  xalu_core u_core (
    .word_i  (in_word_r),
    .flags_i (flags_r),
    .res_o   (alu_res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (adv_out || !in_vld_r) begin
      in_vld_nxt = in_valid;
    end
    out_vld_nxt = out_vld_r;
    if (adv_out) begin
      out_vld_nxt = in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      flags_r   <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (in_vld_r && adv_out) begin
        flags_r <= alu_res.flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) begin
      in_word_r.opcode    <= opcode_t'(in_opcode);
      in_word_r.byte_size <= in_byte_size;
      in_word_r.dst_value <= in_dst_value;
      in_word_r.src_value <= in_src_value;
    end
    if (in_vld_r && adv_out) begin
      out_res_r <= alu_res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_result_value  = out_res_r.result_value;
  assign out_write_dest    = out_res_r.write_dest;
  assign out_zero_flag     = out_res_r.flags.zf;
  assign out_sign_flag     = out_res_r.flags.sf;
  assign out_carry_flag    = out_res_r.flags.cf;
  assign out_overflow_flag = out_res_r.flags.of;

endmodule
`default_nettype wire

/* rtl/xalu_core.sv */
// Combinational ALU datapath: result, write enable and updated flags.
`default_nettype none
module xalu_core
  import xalu_pkg::*;
(
  input  alu_word_t word_i,
  input  flags_t    flags_i,
  output alu_res_t  res_o
);

  logic [31:0] a;
  logic [31:0] b;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [31:0] raw;
  logic [31:0] res;
  logic        res_top;
  logic        res_zero;
  logic        a_top;
  logic        b_top;
  logic        cf;
  logic        of;
  logic        arith;
  logic        logic_op;
  logic        wr;

  assign a = word_i.byte_size ? {24'd0, word_i.dst_value[BYTE_TOP:0]} : word_i.dst_value;
  assign b = word_i.byte_size ? {24'd0, word_i.src_value[BYTE_TOP:0]} : word_i.src_value;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  assign a_top = word_i.byte_size ? a[BYTE_TOP] : a[WORD_TOP];
  assign b_top = word_i.byte_size ? b[BYTE_TOP] : b[WORD_TOP];

  always_comb begin
    raw      = a;
    cf       = 1'b0;
    wr       = 1'b0;
    arith    = 1'b0;
    logic_op = 1'b0;
    case (word_i.opcode)
      OP_ADD: begin
        raw   = sum[31:0];
        cf    = word_i.byte_size ? sum[BYTE_BITS] : sum[WORD_BITS];
        wr    = 1'b1;
        arith = 1'b1;
      end
      OP_SUB, OP_CMP: begin
        raw   = diff[31:0];
        cf    = word_i.byte_size ? diff[BYTE_BITS] : diff[WORD_BITS];
        wr    = (word_i.opcode == OP_SUB);
        arith = 1'b1;
      end
      OP_MOV: begin
        raw = b;
        wr  = 1'b1;
      end
      OP_XOR: begin
        raw      = a ^ b;
        wr       = 1'b1;
        logic_op = 1'b1;
      end
      OP_AND: begin
        raw      = a & b;
        wr       = 1'b1;
        logic_op = 1'b1;
      end
      OP_OR: begin
        raw      = a | b;
        wr       = 1'b1;
        logic_op = 1'b1;
      end
      default: begin
        raw = a;
      end
    endcase
  end

  assign res      = word_i.byte_size ? {24'd0, raw[BYTE_TOP:0]} : raw;
  assign res_top  = word_i.byte_size ? res[BYTE_TOP] : res[WORD_TOP];
  assign res_zero = (res == 32'd0);

  // add: operands agree in sign, result differs; sub: operands differ, result follows b
  always_comb begin
    if (word_i.opcode == OP_ADD) begin
      of = (a_top ^ res_top) & (b_top ^ res_top);
    end else begin
      of = (a_top ^ b_top) & (a_top ^ res_top);
    end
  end

  always_comb begin
    res_o.flags = flags_i;
    if (arith || logic_op) begin
      res_o.flags.zf = res_zero;
      res_o.flags.sf = res_top;
      res_o.flags.cf = arith & cf;
      res_o.flags.of = arith & of;
    end
    res_o.write_dest = wr;
    if (!wr) begin
      res_o.result_value = word_i.dst_value;
    end else if (word_i.byte_size) begin
      res_o.result_value = {word_i.dst_value[31:BYTE_BITS], res[BYTE_TOP:0]};
    end else begin
      res_o.result_value = res;
    end
  end

endmodule
`default_nettype wire

/* rtl/xalu_chk.sv */
// Port-level checker for the x86 ALU and its bind to the top level.
`default_nettype none
`include "x86_alu_with_flags_assert.svh"
module xalu_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_result_value,
  input wire logic        out_write_dest,
  input wire logic        out_zero_flag,
  input wire logic        out_sign_flag,
  input wire logic        out_carry_flag,
  input wire logic        out_overflow_flag
);

  `XALU_ASSERT_NEXT(a_out_hold_valid, out_valid && out_stall, out_valid)
  `XALU_ASSERT_NEXT(a_out_hold_word, out_valid && out_stall, $stable(out_result_value) && $stable(out_write_dest) && $stable({out_zero_flag, out_sign_flag, out_carry_flag, out_overflow_flag}))
  `XALU_ASSERT_NOW(a_no_stall_when_drained, !out_stall, !in_stall)
  `XALU_ASSERT_NOW(a_zf_sf_exclusive, out_valid, !(out_zero_flag && out_sign_flag))

endmodule

bind x86_alu_with_flags xalu_chk u_xalu_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_result_value  (out_result_value),
  .out_write_dest    (out_write_dest),
  .out_zero_flag     (out_zero_flag),
  .out_sign_flag     (out_sign_flag),
  .out_carry_flag    (out_carry_flag),
  .out_overflow_flag (out_overflow_flag)
);
`default_nettype wire

/* tb/sv/x86_alu_with_flags_test.sv */
// Self-checking testbench for the x86 ALU: predicted words vs. the block, under idle/stall phases.
`timescale 1ns / 1ps
module x86_alu_with_flags_test;
  import xalu_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 450;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_opcode;
  logic        in_byte_size;
  logic [31:0] in_dst_value;
  logic [31:0] in_src_value;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_result_value;
  logic        out_write_dest;
  logic        out_zero_flag;
  logic        out_sign_flag;
  logic        out_carry_flag;
  logic        out_overflow_flag;

  x86_alu_with_flags u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_byte_size      (in_byte_size),
    .in_dst_value      (in_dst_value),
    .in_src_value      (in_src_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_write_dest    (out_write_dest),
    .out_zero_flag     (out_zero_flag),
    .out_sign_flag     (out_sign_flag),
    .out_carry_flag    (out_carry_flag),
    .out_overflow_flag (out_overflow_flag)
  );

  flags_t   flag_state;
  alu_res_t expected_q[$];
  int       mismatches;
  int       cycles;
  int       idle_pct;
  int       stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Flag-keeping ALU prediction for one word.
  function automatic alu_res_t alu_predict(logic [2:0] op, logic byte_mode,
                                           logic [31:0] dst, logic [31:0] src);
    logic [31:0] mask;
    int          top;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] res;
    logic        cf;
    logic        of;
    logic        wr;
    logic        arith;
    logic        logic_op;
    alu_res_t    r;
    mask     = byte_mode ? 32'h0000_00FF : 32'hFFFF_FFFF;
    top      = byte_mode ? BYTE_TOP : WORD_TOP;
    a        = dst & mask;
    b        = src & mask;
    res      = a;
    cf       = 1'b0;
    of       = 1'b0;
    wr       = 1'b0;
    arith    = 1'b0;
    logic_op = 1'b0;
    case (op)
      OP_ADD: begin
        res   = (a + b) & mask;
        cf    = res < a;
        of    = (a[top] ^ res[top]) & (b[top] ^ res[top]);
        wr    = 1'b1;
        arith = 1'b1;
      end
      OP_SUB, OP_CMP: begin
        res   = (a - b) & mask;
        cf    = a < b;
        of    = (a[top] ^ b[top]) & (a[top] ^ res[top]);
        wr    = (op == OP_SUB);
        arith = 1'b1;
      end
      OP_MOV: begin
        res = b;
        wr  = 1'b1;
      end
      OP_XOR: begin
        res      = a ^ b;
        wr       = 1'b1;
        logic_op = 1'b1;
      end
      OP_AND: begin
        res      = a & b;
        wr       = 1'b1;
        logic_op = 1'b1;
      end
      OP_OR: begin
        res      = a | b;
        wr       = 1'b1;
        logic_op = 1'b1;
      end
      default: ;
    endcase
    if (arith || logic_op) begin
      flag_state.zf = (res == 32'd0);
      flag_state.sf = res[top];
      flag_state.cf = arith & cf;
      flag_state.of = arith & of;
    end
    r.result_value = wr ? ((dst & ~mask) | res) : dst;
    r.write_dest   = wr;
    r.flags        = flag_state;
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(logic [2:0] op, logic byte_mode, logic [31:0] dst,
                           logic [31:0] src);
    logic taken;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_byte_size <= byte_mode;
    in_dst_value <= dst;
    in_src_value <= src;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) expected_q.push_back(alu_predict(op, byte_mode, dst, src));
      @(posedge clk);
    end
  endtask

  always @(negedge clk) begin
    alu_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result word: value=%h wr=%b", out_result_value, out_write_dest);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_result_value !== exp_r.result_value || out_write_dest !== exp_r.write_dest ||
            out_zero_flag !== exp_r.flags.zf || out_sign_flag !== exp_r.flags.sf ||
            out_carry_flag !== exp_r.flags.cf || out_overflow_flag !== exp_r.flags.of) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"mismatch: exp value=%h wr=%b zf=%b sf=%b cf=%b of=%b",
                      "  got value=%h wr=%b zf=%b sf=%b cf=%b of=%b"},
                     exp_r.result_value, exp_r.write_dest, exp_r.flags.zf, exp_r.flags.sf,
                     exp_r.flags.cf, exp_r.flags.of, out_result_value, out_write_dest,
                     out_zero_flag, out_sign_flag, out_carry_flag, out_overflow_flag);
        end
      end
    end
  end

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(9))
      0: v = 32'h0000_0000;
      1: v = 32'hFFFF_FFFF;
      2: v = 32'h7FFF_FFFF;
      3: v = 32'h8000_0000;
      4: v[7:0] = 8'h00;
      5: v[7:0] = 8'h7F;
      6: v[7:0] = 8'h80;
      7: v[7:0] = 8'hFF;
      default: ;
    endcase
    return v;
  endfunction

  task automatic run_random(int count);
    logic [2:0]  op;
    logic [31:0] dst;
    logic [31:0] src;
    for (int i = 0; i < count; i++) begin
      op  = ($urandom_range(29) == 0) ? OP_UNUSED : 3'($urandom_range(6));
      dst = pick_operand();
      src = ($urandom_range(7) == 0) ? dst : pick_operand();
      send_word(op, 1'($urandom_range(1)), dst, src);
    end
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_word(OP_ADD, 1'b0, 32'hFFFF_FFFF, 32'h0000_0001);
    send_word(OP_ADD, 1'b0, 32'h7FFF_FFFF, 32'h0000_0001);
    send_word(OP_ADD, 1'b0, 32'h8000_0000, 32'h8000_0000);
    send_word(OP_MOV, 1'b0, 32'h1234_5678, 32'hDEAD_BEEF);
    send_word(OP_SUB, 1'b0, 32'h0000_0000, 32'h0000_0001);
    send_word(OP_SUB, 1'b0, 32'h8000_0000, 32'h0000_0001);
    send_word(OP_CMP, 1'b0, 32'hCAFE_0001, 32'hCAFE_0001);
    send_word(OP_CMP, 1'b0, 32'h0000_0005, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 1'b0, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
    send_word(OP_XOR, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_AND, 1'b0, 32'hF000_000F, 32'h8000_00FF);
    send_word(OP_OR,  1'b0, 32'h0000_0000, 32'h0000_0000);
    send_word(OP_ADD, 1'b1, 32'hABCD_EFFF, 32'h1234_5601);
    send_word(OP_ADD, 1'b1, 32'h0000_007F, 32'hFFFF_FF01);
    send_word(OP_SUB, 1'b1, 32'hFFFF_FF00, 32'h0000_0001);
    send_word(OP_SUB, 1'b1, 32'h1234_5680, 32'h0000_0001);
    send_word(OP_CMP, 1'b1, 32'h9999_9910, 32'h0000_0020);
    send_word(OP_AND, 1'b1, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_word(OP_OR,  1'b1, 32'h0000_0080, 32'hFFFF_FF00);
    send_word(OP_XOR, 1'b1, 32'h5555_5555, 32'hAAAA_AA55);
    send_word(OP_MOV, 1'b1, 32'h8765_4321, 32'hFFFF_FFAB);
    send_word(OP_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_MOV, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  task automatic test_random_no_idle();
    idle_pct  = 0;
    stall_pct = 0;
    run_random(RANDOM_PER_PHASE);
  endtask

  task automatic test_random_sender_idle();
    idle_pct  = 53;
    stall_pct = 0;
    run_random(RANDOM_PER_PHASE);
  endtask

  task automatic test_random_receiver_stall();
    idle_pct  = 0;
    stall_pct = 53;
    run_random(RANDOM_PER_PHASE);
  endtask

  task automatic test_random_both_idle();
    idle_pct  = 23;
    stall_pct = 23;
    run_random(RANDOM_PER_PHASE);
  endtask

  initial begin
    mismatches   = 0;
    cycles       = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    flag_state   = '0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_opcode    <= OP_ADD;
    in_byte_size <= 1'b0;
    in_dst_value <= 32'd0;
    in_src_value <= 32'd0;
    out_stall    <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    in_valid <= 1'b0;
    stall_pct = 0;
    wait (expected_q.size() == 0);
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0) mismatches = mismatches + 1;
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
